>>> design/tagged_min_heap_priority_queue_unit_assert.svh
// Assertion macros for the tagged min-heap priority queue.
// Used by the port checker; no other dependencies.
`ifndef TAGGED_MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define TAGGED_MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
// Implication checked on every edge out of reset.
`define TMHQ_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("tmhq check failed");
// Next-cycle implication.
`define TMHQ_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("tmhq check failed");
`endif

>>> design/tmhq_pkg.sv
// Shared types, constants and state codes for the tagged min-heap queue.
// No dependencies.
package tmhq_pkg;
  localparam int HeapDepth = 64;
  localparam int AddrW     = $clog2(HeapDepth);
  localparam int CntW      = $clog2(HeapDepth + 1);

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_REM_MIN = 2'd1;
  localparam logic [1:0] OP_REM_TAG = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_NOTAG   = 2'd3;

  typedef struct packed {
    logic [7:0]  tag;
    logic [15:0] count;
    logic [15:0] order;
  } entry_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  entry_tag;
    logic [15:0] entry_count;
    logic [15:0] entry_order;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  removed_tag;
    logic [15:0] removed_count;
    logic [15:0] removed_order;
    logic [6:0]  occupancy;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_CHK, S_TAKE_RD, S_TAKE_WR,
    S_UP_RD, S_UP_CHK, S_DN_RD, S_DN_CHK, S_RESULT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch_in;      // capture the request
    logic ins_write;     // write new entry at slot total, total++
    logic scan_start;    // scan index to zero
    logic scan_read;     // read slot at scan index
    logic scan_next;     // advance scan index
    logic take_read;     // read last entry and hole
    logic take_write;    // move last into hole, total--
    logic up_read;       // read cur and parent
    logic up_swap;       // exchange cur with parent
    logic dn_read;       // read both children
    logic dn_swap;       // exchange cur with chosen child
    logic set_status;    // load status into result
    logic [1:0] status;
    logic out_load;      // present result
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] op;
    logic empty;
    logic full;
    logic scan_hit;
    logic scan_end;
    logic hole_valid;    // hole index below new total
    logic hole_up;       // moved entry has already sifted up
    logic up_go;         // cur precedes parent and cur > 0
    logic dn_go;         // chosen child precedes cur
    logic out_busy;
  } stat_t;

  function automatic logic precedes(entry_t a, entry_t b);
    if (a.count != b.count) return a.count < b.count;
    return a.order < b.order;
  endfunction
endpackage

>>> design/tmhq_ctrl.sv
// Controller state machine for the tagged min-heap queue.
// Depends on tmhq_pkg.
module tmhq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tmhq_pkg::stat_t  st,
  output tmhq_pkg::cmd_t   cmd
);
  tmhq_pkg::state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tmhq_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // Sequence one request
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      tmhq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt = tmhq_pkg::S_DECODE;
        end
      end
      tmhq_pkg::S_DECODE: begin
        case (st.op)
          tmhq_pkg::OP_INSERT: begin
            if (st.full) begin
              cmd.set_status = 1'b1; cmd.status = tmhq_pkg::ST_FULL;
              state_nxt = tmhq_pkg::S_RESULT;
            end else begin
              cmd.ins_write = 1'b1;
              state_nxt = tmhq_pkg::S_UP_RD;
            end
          end
          tmhq_pkg::OP_REM_MIN: begin
            if (st.empty) begin
              cmd.set_status = 1'b1; cmd.status = tmhq_pkg::ST_EMPTY;
              state_nxt = tmhq_pkg::S_RESULT;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt = tmhq_pkg::S_TAKE_RD;
            end
          end
          tmhq_pkg::OP_REM_TAG: begin
            if (st.empty) begin
              cmd.set_status = 1'b1; cmd.status = tmhq_pkg::ST_EMPTY;
              state_nxt = tmhq_pkg::S_RESULT;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt = tmhq_pkg::S_SCAN_RD;
            end
          end
          default: begin
            cmd.set_status = 1'b1; cmd.status = tmhq_pkg::ST_DONE;
            state_nxt = tmhq_pkg::S_RESULT;
          end
        endcase
      end
      tmhq_pkg::S_SCAN_RD: begin
        cmd.scan_read = 1'b1;
        state_nxt = tmhq_pkg::S_SCAN_CHK;
      end
      tmhq_pkg::S_SCAN_CHK: begin
        if (st.scan_hit) state_nxt = tmhq_pkg::S_TAKE_RD;
        else if (st.scan_end) begin
          cmd.set_status = 1'b1; cmd.status = tmhq_pkg::ST_NOTAG;
          state_nxt = tmhq_pkg::S_RESULT;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt = tmhq_pkg::S_SCAN_RD;
        end
      end
      tmhq_pkg::S_TAKE_RD: begin
        cmd.take_read = 1'b1;
        state_nxt = tmhq_pkg::S_TAKE_WR;
      end
      tmhq_pkg::S_TAKE_WR: begin
        cmd.take_write = 1'b1;
        state_nxt = tmhq_pkg::S_UP_RD;
      end
      tmhq_pkg::S_UP_RD: begin
        cmd.up_read = 1'b1;
        state_nxt = tmhq_pkg::S_UP_CHK;
      end
      tmhq_pkg::S_UP_CHK: begin
        // after a removal the hole decides the direction
        if (st.up_go) begin
          cmd.up_swap = 1'b1;
          state_nxt = tmhq_pkg::S_UP_RD;
        end else if (st.op != tmhq_pkg::OP_INSERT && st.hole_valid && !st.hole_up) begin
          state_nxt = tmhq_pkg::S_DN_RD;
        end else begin
          cmd.set_status = 1'b1; cmd.status = tmhq_pkg::ST_DONE;
          state_nxt = tmhq_pkg::S_RESULT;
        end
      end
      tmhq_pkg::S_DN_RD: begin
        cmd.dn_read = 1'b1;
        state_nxt = tmhq_pkg::S_DN_CHK;
      end
      tmhq_pkg::S_DN_CHK: begin
        if (st.dn_go) begin
          cmd.dn_swap = 1'b1;
          state_nxt = tmhq_pkg::S_DN_RD;
        end else begin
          cmd.set_status = 1'b1; cmd.status = tmhq_pkg::ST_DONE;
          state_nxt = tmhq_pkg::S_RESULT;
        end
      end
      tmhq_pkg::S_RESULT: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = tmhq_pkg::S_IDLE;
        end
      end
      default: state_nxt = tmhq_pkg::S_IDLE;
    endcase
  end
endmodule

>>> design/tmhq_datapath.sv
// Heap store, indices, comparators and output register of the heap queue.
// Depends on tmhq_pkg.
module tmhq_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tmhq_pkg::in_item_t   in_data,
  input  logic                 cfg_valid,
  input  logic [6:0]           cfg_data,
  input  tmhq_pkg::cmd_t       cmd,
  output tmhq_pkg::stat_t      st,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tmhq_pkg::out_item_t  out_data
);
  localparam int AW = tmhq_pkg::AddrW;
  localparam int CW = tmhq_pkg::CntW;

  tmhq_pkg::entry_t mem [tmhq_pkg::HeapDepth];

  tmhq_pkg::in_item_t  req_r;
  logic [6:0]          cap_r;
  logic [CW-1:0]       total_r;
  logic [AW-1:0]       cur_r, hole_r;
  tmhq_pkg::entry_t    a_r, b_r, c_r;   // cur, parent/left, right
  logic                rvalid_r;        // right child exists
  logic                lvalid_r;        // left child exists
  tmhq_pkg::out_item_t res_r, out_r;
  logic                out_valid_r;
  logic                hole_up_r;

  logic [AW-1:0] parent, lidx, ridx;
  logic [CW:0]   lwide, rwide;
  logic [CW-1:0] cap_eff;
  logic          pick_l;
  tmhq_pkg::entry_t pick_e;
  logic [AW-1:0]    pick_i;
  logic [CW-1:0]    last_w;

  assign parent = (cur_r - AW'(1)) >> 1;
  assign lwide  = {cur_r, 1'b1} + (CW+1)'(0);
  assign rwide  = lwide + (CW+1)'(1);
  assign lidx   = lwide[AW-1:0];
  assign ridx   = rwide[AW-1:0];
  assign cap_eff = (cap_r > 7'(tmhq_pkg::HeapDepth)) ? CW'(tmhq_pkg::HeapDepth) : CW'(cap_r);
  assign last_w = total_r - CW'(1);
  assign pick_l = !rvalid_r || tmhq_pkg::precedes(b_r, c_r);
  assign pick_e = pick_l ? b_r : c_r;
  assign pick_i = pick_l ? lidx : ridx;

  // Report status to the controller
  always_comb begin
    st.op         = req_r.operation;
    st.empty      = (total_r == '0);
    st.full       = (total_r >= cap_eff);
    st.scan_hit   = (a_r.tag == req_r.entry_tag);
    st.scan_end   = (CW'(cur_r) == last_w);
    st.hole_valid = (CW'(hole_r) < total_r);
    st.hole_up    = hole_up_r;
    st.up_go      = (cur_r != '0) && tmhq_pkg::precedes(a_r, b_r);
    st.dn_go      = lvalid_r && tmhq_pkg::precedes(pick_e, a_r);
    st.out_busy   = out_valid_r && !out_ready;
  end

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= 7'd64;
    else if (cfg_valid) cap_r <= cfg_data;
  end

  // Heap store and its working registers; the moving entry stays in a_r
  always_ff @(posedge clk) begin
    if (cmd.latch_in) req_r <= in_data;
    if (cmd.ins_write) begin
      mem[total_r[AW-1:0]] <= '{tag: req_r.entry_tag, count: req_r.entry_count,
                               order: req_r.entry_order};
      cur_r <= total_r[AW-1:0];
    end
    if (cmd.scan_start) cur_r <= '0;
    if (cmd.scan_next)  cur_r <= cur_r + AW'(1);
    if (cmd.scan_read || cmd.up_read) a_r <= mem[cur_r];
    if (cmd.up_read) b_r <= mem[parent];
    if (cmd.dn_read) begin
      b_r <= mem[lidx];
      c_r <= mem[ridx];
      lvalid_r <= (lwide < (CW+1)'(total_r));
      rvalid_r <= (rwide < (CW+1)'(total_r));
    end
    if (cmd.take_read) begin
      a_r <= mem[cur_r];
      b_r <= mem[last_w[AW-1:0]];
      hole_r <= cur_r;
    end
    if (cmd.take_write) begin
      mem[cur_r] <= b_r;
      res_r.removed_tag   <= a_r.tag;
      res_r.removed_count <= a_r.count;
      res_r.removed_order <= a_r.order;
      hole_up_r <= 1'b0;
    end
    // note that the moved entry has gone up, so no sift-down follows
    if (cmd.up_swap) begin
      mem[cur_r]  <= b_r;
      mem[parent] <= a_r;
      cur_r <= parent;
      hole_up_r <= 1'b1;
    end
    if (cmd.dn_swap) begin
      mem[cur_r]  <= pick_e;
      mem[pick_i] <= a_r;
      cur_r <= pick_i;
    end
    if (cmd.latch_in) begin
      res_r.removed_tag <= '0; res_r.removed_count <= '0; res_r.removed_order <= '0;
    end
    if (cmd.set_status) res_r.status <= cmd.status;
    if (cmd.out_load) out_r <= '{status: res_r.status, removed_tag: res_r.removed_tag,
                                 removed_count: res_r.removed_count,
                                 removed_order: res_r.removed_order,
                                 occupancy: 7'(total_r)};
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (!rst_n) total_r <= '0;
    else if (cmd.ins_write) total_r <= total_r + CW'(1);
    else if (cmd.take_write) total_r <= last_w;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

>>> design/tagged_min_heap_priority_queue_unit.sv
// Top level of the tagged min-heap priority queue.
// Depends on tmhq_pkg, tmhq_ctrl and tmhq_datapath.
//
// One request at a time. An insert writes the new entry at the end of the heap
// and sifts it up level by level; a removal reads the hole and the last entry,
// moves the last entry into the hole and then sifts it up or down (remove-minimum
// only down), with no sift when the last entry itself is removed; remove-by-tag
// first scans the entries (up to 64) for the tag before the removal. Each step is set
// by the registered reads of the heap store, at most two a cycle. The result
// sits in an output register, so the next request is taken once the result
// is loaded.
module tagged_min_heap_priority_queue_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tmhq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tmhq_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [6:0]           cfg_data
);
  tmhq_pkg::cmd_t  cmd;
  tmhq_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  tmhq_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_ready, .st, .cmd);
  tmhq_datapath u_dp (.clk, .rst_n, .in_data, .cfg_valid, .cfg_data, .cmd, .st,
                      .out_valid, .out_ready, .out_data);
endmodule

>>> design/tmhq_checker.sv
// Port checker for the tagged min-heap queue, bound to the top level.
// Depends on tmhq_pkg and the assertion macro header.
`include "tagged_min_heap_priority_queue_unit_assert.svh"
module tmhq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input tmhq_pkg::out_item_t out_data
);
  `TMHQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `TMHQ_ASSERT_NEXT(a_one_at_time, clk, rst_n, in_valid && in_ready, !in_ready)
  `TMHQ_ASSERT_IMPL(a_occ_range, clk, rst_n, out_valid, out_data.occupancy <= 7'd64)
  `TMHQ_ASSERT_IMPL(a_zero_fields, clk, rst_n, out_valid && out_data.status != tmhq_pkg::ST_DONE, out_data.removed_tag == 8'd0 && out_data.removed_count == 16'd0)
endmodule

bind tagged_min_heap_priority_queue_unit tmhq_checker u_chk (.clk, .rst_n, .in_valid,
  .in_ready, .out_valid, .out_ready, .out_data);

>>> tb/tb_tagged_min_heap_priority_queue_unit.sv
// Testbench for the tagged min-heap priority queue unit.
// Depends on tmhq_pkg and tagged_min_heap_priority_queue_unit; predicts every
// result with its own heap model and checks each result transaction in order.
module tb_tagged_min_heap_priority_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxCycles = 2000000;
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  tmhq_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  tmhq_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [6:0]          cfg_data;

  tagged_min_heap_priority_queue_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state
  tmhq_pkg::entry_t    heap_copy [tmhq_pkg::HeapDepth];
  int                  heap_size;
  int                  limit_copy;
  tmhq_pkg::out_item_t pending_results [$];
  int                  error_count = 0;
  int                  cycle_count = 0;
  logic                sink_stall_on;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Abort on timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic entry_before(tmhq_pkg::entry_t a, tmhq_pkg::entry_t b);
    if (a.count != b.count) return a.count < b.count;
    return a.order < b.order;
  endfunction

  function automatic void swap_slots(int a, int b);
    tmhq_pkg::entry_t t;
    t = heap_copy[a];
    heap_copy[a] = heap_copy[b];
    heap_copy[b] = t;
  endfunction

  function automatic void float_up(int p);
    int up;
    while (p > 0) begin
      up = (p - 1) / 2;
      if (!entry_before(heap_copy[p], heap_copy[up])) return;
      swap_slots(p, up);
      p = up;
    end
  endfunction

  function automatic void sink_down(int p);
    int l;
    int pick;
    forever begin
      l = 2 * p + 1;
      if (l >= heap_size) return;
      if (l + 1 >= heap_size || entry_before(heap_copy[l], heap_copy[l + 1])) pick = l;
      else pick = l + 1;
      if (!entry_before(heap_copy[pick], heap_copy[p])) return;
      swap_slots(p, pick);
      p = pick;
    end
  endfunction

  function automatic void extract_slot(int p, inout tmhq_pkg::out_item_t r);
    r.removed_tag   = heap_copy[p].tag;
    r.removed_count = heap_copy[p].count;
    r.removed_order = heap_copy[p].order;
    if (p != heap_size - 1) swap_slots(p, heap_size - 1);
    heap_size--;
    if (p < heap_size) begin
      if (p > 0 && entry_before(heap_copy[p], heap_copy[(p - 1) / 2])) float_up(p);
      else sink_down(p);
    end
  endfunction

  // Work out the result of one request and update the model heap
  function automatic tmhq_pkg::out_item_t predict_request(tmhq_pkg::in_item_t req);
    tmhq_pkg::out_item_t r;
    int cap;
    int i;
    r = '0;
    cap = (limit_copy < tmhq_pkg::HeapDepth) ? limit_copy : tmhq_pkg::HeapDepth;
    case (req.operation)
      tmhq_pkg::OP_INSERT: begin
        if (heap_size >= cap) r.status = tmhq_pkg::ST_FULL;
        else begin
          heap_copy[heap_size] = '{req.entry_tag, req.entry_count, req.entry_order};
          heap_size++;
          float_up(heap_size - 1);
        end
      end
      tmhq_pkg::OP_REM_MIN: begin
        if (heap_size == 0) r.status = tmhq_pkg::ST_EMPTY;
        else extract_slot(0, r);
      end
      tmhq_pkg::OP_REM_TAG: begin
        if (heap_size == 0) r.status = tmhq_pkg::ST_EMPTY;
        else begin
          for (i = 0; i < heap_size; i++)
            if (heap_copy[i].tag == req.entry_tag) break;
          if (i >= heap_size) r.status = tmhq_pkg::ST_NOTAG;
          else extract_slot(i, r);
        end
      end
      default: ;
    endcase
    r.occupancy = 7'(heap_size);
    return r;
  endfunction

  // Append one prediction behind those still waiting
  function automatic void queue_expected(tmhq_pkg::out_item_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        tmhq_pkg::out_item_t e;
        e = pending_results.pop_front();
        if (out_data.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
          error_count++;
        end
        if (out_data.removed_tag !== e.removed_tag) begin
          $display("%0t: removed_tag expected %0d actual %0d", $time,
                   e.removed_tag, out_data.removed_tag);
          error_count++;
        end
        if (out_data.removed_count !== e.removed_count) begin
          $display("%0t: removed_count expected %0d actual %0d", $time,
                   e.removed_count, out_data.removed_count);
          error_count++;
        end
        if (out_data.removed_order !== e.removed_order) begin
          $display("%0t: removed_order expected %0d actual %0d", $time,
                   e.removed_order, out_data.removed_order);
          error_count++;
        end
        if (out_data.occupancy !== e.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time,
                   e.occupancy, out_data.occupancy);
          error_count++;
        end
      end
    end
  end

  // Random back-pressure on the result channel
  initial begin
    int g;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (sink_stall_on) begin
        g = pick_gap();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Send one request transaction, after a random gap when gaps is set; valid is dropped only
  // for a gap or when the input goes idle
  task automatic send_request(logic [1:0] op, logic [7:0] tag, logic [15:0] cnt,
                              logic [15:0] ord, bit gaps = 1'b1);
    int g;
    tmhq_pkg::in_item_t req;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req = '{op, tag, cnt, ord};
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    queue_expected(predict_request(req));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_limit(int value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= 7'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_copy = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Directed: empty removals, extremes, ties, full heap, spare code
  task automatic test_directed();
    send_request(tmhq_pkg::OP_REM_MIN, 8'h00, 16'h0, 16'h0);
    send_request(tmhq_pkg::OP_REM_TAG, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(tmhq_pkg::OP_INSERT, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(tmhq_pkg::OP_INSERT, 8'h00, 16'h0000, 16'h0000);
    send_request(tmhq_pkg::OP_INSERT, 8'h5A, 16'h0010, 16'h0002);
    send_request(tmhq_pkg::OP_INSERT, 8'hA5, 16'h0010, 16'h0001);
    send_request(tmhq_pkg::OP_INSERT, 8'h33, 16'h0010, 16'h0001);
    send_request(OP_SPARE, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(tmhq_pkg::OP_REM_TAG, 8'h77, 16'h0, 16'h0);
    send_request(tmhq_pkg::OP_REM_TAG, 8'h5A, 16'h0, 16'h0);
    send_request(tmhq_pkg::OP_REM_MIN, 8'h00, 16'h0, 16'h0);
    send_request(tmhq_pkg::OP_REM_MIN, 8'h00, 16'h0, 16'h0);
    write_limit(2);
    send_request(tmhq_pkg::OP_INSERT, 8'h11, 16'h0001, 16'h0);
    send_request(tmhq_pkg::OP_INSERT, 8'h12, 16'h0002, 16'h0);
    send_request(tmhq_pkg::OP_INSERT, 8'h13, 16'h0003, 16'h0);
    write_limit(0);
    send_request(tmhq_pkg::OP_INSERT, 8'h14, 16'h0004, 16'h0);
    send_request(tmhq_pkg::OP_REM_MIN, 8'h00, 16'h0, 16'h0);
    send_request(tmhq_pkg::OP_REM_MIN, 8'h00, 16'h0, 16'h0);
    send_request(tmhq_pkg::OP_REM_MIN, 8'h00, 16'h0, 16'h0);
    send_request(tmhq_pkg::OP_REM_MIN, 8'h00, 16'h0, 16'h0);
  endtask

  // Random: fill and drain phases at several limits, small tag pool for hits
  task automatic test_random_phase(int limit, int items, bit gaps);
    int fill_bias;
    int r;
    logic [1:0] op;
    logic [7:0] tag;
    write_limit(limit);
    for (int n = 0; n < items; n++) begin
      fill_bias = ((n / 40) % 2 == 0) ? 70 : 30;
      r = $urandom_range(0, 99);
      if (r < 2) op = OP_SPARE;
      else if (r < fill_bias) op = tmhq_pkg::OP_INSERT;
      else if ($urandom_range(0, 1)) op = tmhq_pkg::OP_REM_MIN;
      else op = tmhq_pkg::OP_REM_TAG;
      tag = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 15));
      send_request(op, tag,
                   $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 7)),
                   $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3)),
                   gaps);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    heap_size = 0;
    limit_copy = 64;
    sink_stall_on = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(64, 500, 1'b1);
    test_random_phase(127, 300, 1'b1);
    test_random_phase(1, 100, 1'b1);
    test_random_phase(7, 150, 1'b1);
    sink_stall_on = 1'b0;
    test_random_phase(64, 200, 1'b0);
    sink_stall_on = 1'b1;
    test_random_phase(3, 100, 1'b1);
    wait_idle();
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
